### sv/insertion_sorter_unit_defines.svh
// Assertion macros for the insertion sorter checker.
// Each macro expects signals named clk and arst_n in the scope of use.
`ifndef INSERTION_SORTER_UNIT_DEFINES_SVH
`define INSERTION_SORTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ISU_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define ISU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/iss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package iss_pkg;

	localparam int unsigned DATA_W = 32;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     is_last;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic                     end_of_list;
		logic                     overflowed;
	} out_item_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic accept;    // capture the incoming item
		logic rd_prev;   // read the entry below the insert position
		logic wr_shift;  // move the read entry up one place
		logic wr_place;  // write the new value at the insert position
		logic rd_out;    // read the entry at the output index
		logic load_out;  // load the read entry into the result register
		logic out_next;  // result taken: advance or finish the set
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic full;      // store holds the maximum number of entries
		logic pos_zero;  // insert position reached the bottom
		logic gt;        // read entry is strictly greater than the new value
		logic last;      // captured item closes the set
		logic out_taken; // result register handed over this cycle
		logic out_end;   // result register holds the final entry
	} status_t;

endpackage

`default_nettype wire

### sv/iss_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module iss_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire iss_pkg::status_t status,
	output iss_pkg::cmd_t         cmd
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_INS   = 6'b000010,
		ST_CMP   = 6'b000100,
		ST_ORD   = 6'b001000,
		ST_OLD   = 6'b010000,
		ST_OHOLD = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign item_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_INS;
				end
			end
			ST_INS: begin
				if (status.full) begin
					// drop the value; drop flag was set on capture
					state_d = status.last ? ST_ORD : ST_IDLE;
				end else if (status.pos_zero) begin
					cmd.wr_place = 1'b1;
					state_d      = status.last ? ST_ORD : ST_IDLE;
				end else begin
					cmd.rd_prev = 1'b1;
					state_d     = ST_CMP;
				end
			end
			ST_CMP: begin
				if (status.gt) begin
					cmd.wr_shift = 1'b1;
					state_d      = ST_INS;
				end else begin
					cmd.wr_place = 1'b1;
					state_d      = status.last ? ST_ORD : ST_IDLE;
				end
			end
			ST_ORD: begin
				cmd.rd_out = 1'b1;
				state_d    = ST_OLD;
			end
			ST_OLD: begin
				cmd.load_out = 1'b1;
				state_d      = ST_OHOLD;
			end
			ST_OHOLD: begin
				if (status.out_taken) begin
					cmd.out_next = 1'b1;
					state_d      = status.out_end ? ST_IDLE : ST_ORD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

### sv/iss_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module iss_datapath #(
	parameter  int unsigned MAX_ITEMS = 64,
	localparam int unsigned CNT_W     = $clog2(MAX_ITEMS + 1),
	localparam int unsigned ADDR_W    = $clog2(MAX_ITEMS)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire iss_pkg::in_item_t item,
	input  wire iss_pkg::cmd_t     cmd,
	input  wire logic              result_stall,
	output iss_pkg::status_t       status,
	output iss_pkg::out_item_t     result,
	output logic                   result_valid
);

	logic [iss_pkg::DATA_W-1:0]        store_q [MAX_ITEMS];
	logic [iss_pkg::DATA_W-1:0]        rdata_q;
	logic signed [iss_pkg::DATA_W-1:0] val_q;
	logic                              last_q;
	logic [CNT_W-1:0]                  fill_q;
	logic [CNT_W-1:0]                  pos_q;
	logic [CNT_W-1:0]                  k_q;
	logic                              drop_q;
	iss_pkg::out_item_t                res_q;
	logic                              res_valid_q;

	logic [CNT_W-1:0]  pos_m1;
	logic [CNT_W-1:0]  k_p1;
	logic [ADDR_W-1:0] rd_addr;
	logic              full;

	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_ITEMS);

	assign pos_m1  = pos_q - CNT_W'(1);
	assign k_p1    = k_q + CNT_W'(1);
	assign full    = (fill_q == FULL_CNT);
	assign rd_addr = cmd.rd_out ? k_q[ADDR_W-1:0] : pos_m1[ADDR_W-1:0];

	// store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr_shift || cmd.wr_place) begin
			store_q[pos_q[ADDR_W-1:0]] <= cmd.wr_shift ? rdata_q : val_q;
		end
		if (cmd.rd_prev || cmd.rd_out) begin
			rdata_q <= store_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			val_q  <= item.value;
			last_q <= item.is_last;
		end
		if (cmd.load_out) begin
			res_q.sorted_value <= rdata_q;
			res_q.end_of_list  <= (k_p1 == fill_q);
			res_q.overflowed   <= drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			pos_q       <= '0;
			k_q         <= '0;
			drop_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				pos_q <= fill_q;
				if (full) begin
					drop_q <= 1'b1;
				end
			end
			if (cmd.wr_shift) begin
				pos_q <= pos_m1;
			end
			if (cmd.wr_place) begin
				fill_q <= fill_q + CNT_W'(1);
			end
			if (cmd.load_out) begin
				res_valid_q <= 1'b1;
			end
			if (cmd.out_next) begin
				res_valid_q <= 1'b0;
				if (res_q.end_of_list) begin
					fill_q <= '0;
					drop_q <= 1'b0;
					k_q    <= '0;
				end else begin
					k_q <= k_p1;
				end
			end
		end
	end

	assign status.full      = full;
	assign status.pos_zero  = (pos_q == '0);
	assign status.gt        = ($signed(rdata_q) > val_q);
	assign status.last      = last_q;
	assign status.out_taken = res_valid_q && !result_stall;
	assign status.out_end   = res_q.end_of_list;

	assign result       = res_q;
	assign result_valid = res_valid_q;

endmodule

`default_nettype wire

### sv/insertion_sorter_unit.sv
// Channel  | Signals                               | Payload
// item     | item_valid, item_stall, item          | value (s32), is_last
// result   | result_valid, result_stall, result    | sorted_value (s32), end_of_list,
//          |                                       | overflowed
//
// Items are taken one at a time. For each stored entry that moves up, the block reads it
// and then compares and writes it on the one store port; the new value is then written
// at the insert position, or nothing is written when the item is dropped on a full store.
// A closing item then emits every entry, each read, loaded and held until it is taken.
// Reset clears the counters, drop flag and controller; the store itself is not cleared.
// item_stall is high whenever the block is busy inserting or emitting a set.
`timescale 1ns / 1ps
`default_nettype none

module insertion_sorter_unit #(
	parameter int unsigned MAX_ITEMS = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire iss_pkg::in_item_t item,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output iss_pkg::out_item_t     result
);

	// command and status between the sequencer and the store datapath
	iss_pkg::cmd_t    cmd;
	iss_pkg::status_t status;

	// Sequencer: accept an item, walk the insert position down while the
	// entry below is strictly greater (keeps equal values in arrival order),
	// then on a closing item stream the store out smallest first.
	iss_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.status     (status),
		.cmd        (cmd)
	);

	// Datapath: sorted store, fill count, drop flag and the result register.
	// Hold the result while stalled; drop values that arrive on a full store.
	iss_datapath #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.result_stall (result_stall),
		.status       (status),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule

`default_nettype wire

### sv/iss_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "insertion_sorter_unit_defines.svh"

module iss_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               item_valid,
	input wire logic               item_stall,
	input wire iss_pkg::in_item_t  item,
	input wire logic               result_valid,
	input wire logic               result_stall,
	input wire iss_pkg::out_item_t result
);

	// a stalled result holds
	`ISU_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

	// no item is taken while a set is being emitted
	`ISU_ASSERT_SAME(a_busy_on_output, result_valid, item_stall, "item accepted during output")

	// an item that does not close the set causes no result right away
	`ISU_ASSERT_NEXT(a_no_early_result, item_valid && !item_stall && !item.is_last, !result_valid, "result without closing item")

	// after the final result is taken, the output goes quiet
	`ISU_ASSERT_NEXT(a_end_clears, result_valid && !result_stall && result.end_of_list, !result_valid, "result after end of list")

endmodule

bind insertion_sorter_unit iss_checker u_iss_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int unsigned STORE_DEPTH = 64;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned SETTLE_CYCLES = 300;
	localparam int unsigned ITEMS_PER_PHASE = 95;
	localparam logic signed [iss_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [iss_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	iss_pkg::in_item_t  item = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	iss_pkg::out_item_t result;

	// mirror of the sorted store, used to build the expected output lists
	logic signed [iss_pkg::DATA_W-1:0] mirror_store [STORE_DEPTH];
	int unsigned                       mirror_fill = 0;
	bit                                mirror_dropped = 1'b0;
	iss_pkg::out_item_t                pending_sorted [$];

	int unsigned        error_count = 0;
	int unsigned        cycle_count = 0;
	int unsigned        send_idle_pct = 0;
	int unsigned        recv_idle_pct = 0;
	int unsigned        hold_req_cnt = 0;
	int unsigned        hold_ack_cnt = 0;
	int unsigned        hold_left = 0;
	iss_pkg::out_item_t want;

	insertion_sorter_unit #(
		.MAX_ITEMS(STORE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic flag_error(input string msg);
		error_count++;
		if (error_count <= 10) begin
			$display("%s", msg);
		end
	endtask

	// Insert one accepted item into the mirror; a closing item dumps the list.
	task automatic insert_and_flush(input iss_pkg::in_item_t it);
		int unsigned pos;
		logic signed [iss_pkg::DATA_W-1:0] v;
		iss_pkg::out_item_t r;
		v = it.value;
		if (mirror_fill >= STORE_DEPTH) begin
			mirror_dropped = 1'b1;
		end else begin
			pos = mirror_fill;
			while (pos > 0 && mirror_store[pos-1] > v) begin
				mirror_store[pos] = mirror_store[pos-1];
				pos--;
			end
			mirror_store[pos] = v;
			mirror_fill++;
		end
		if (it.is_last) begin
			for (int unsigned k = 0; k < mirror_fill; k++) begin
				r.sorted_value = mirror_store[k];
				r.end_of_list = (k + 1 == mirror_fill);
				r.overflowed = mirror_dropped;
				pending_sorted.push_back(r);
			end
			mirror_fill = 0;
			mirror_dropped = 1'b0;
		end
	endtask

	// Offer one item after a random gap; return at the edge that accepts it.
	task automatic send_item(input logic signed [iss_pkg::DATA_W-1:0] v, input bit last);
		iss_pkg::in_item_t it;
		it.value = v;
		it.is_last = last;
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall) begin
			@(posedge clk);
		end
		insert_and_flush(it);
	endtask

	// Drop valid and hold until every expected result has come back.
	task automatic wait_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_sorted.size() != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic logic signed [iss_pkg::DATA_W-1:0] pick_value();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 10) begin
			case ($urandom_range(3))
				0: return VAL_MIN;
				1: return VAL_MAX;
				2: return '0;
				default: return '1;
			endcase
		end else if (r < 35) begin
			// narrow range so that equal values land in the same set
			return 32'($urandom_range(6)) - 32'd3;
		end
		return $urandom;
	endfunction

	task automatic send_set(input int unsigned size);
		for (int unsigned i = 0; i < size; i++) begin
			send_item(pick_value(), i + 1 == size);
		end
	endtask

	task automatic test_extremes();
		send_item(VAL_MIN, 1'b1);
		send_item(VAL_MAX, 1'b1);
		send_item(32'sd0, 1'b0);
		send_item(-32'sd1, 1'b0);
		send_item(32'sd1, 1'b0);
		send_item(VAL_MAX, 1'b0);
		send_item(VAL_MIN, 1'b0);
		send_item(VAL_MIN, 1'b1);
		wait_drained();
	endtask

	task automatic test_ties();
		send_item(32'sd5, 1'b0);
		send_item(32'sd5, 1'b0);
		send_item(-32'sd3, 1'b0);
		send_item(32'sd5, 1'b0);
		send_item(-32'sd3, 1'b1);
		send_item(32'sd7, 1'b0);
		send_item(32'sd7, 1'b0);
		send_item(32'sd7, 1'b1);
		wait_drained();
	endtask

	// Descending input shifts every entry; ascending input shifts none.
	task automatic test_order();
		for (int i = 4; i >= 0; i--) begin
			send_item(32'(i * 1000), i == 0);
		end
		for (int i = 0; i < 5; i++) begin
			send_item(32'(i * 1000 - 2000), i == 4);
		end
		wait_drained();
	endtask

	// Hold the result side for a long stretch while items keep coming, so the
	// block stops taking items during the blocked output.
	task automatic test_backpressure();
		send_idle_pct = 0;
		hold_req_cnt <= hold_req_cnt + 1;
		for (int s = 0; s < 3; s++) begin
			send_set($urandom_range(6, 3));
		end
		wait_drained();
	endtask

	// Mostly short sets, with one long set per phase that reaches the store limit.
	task automatic test_random_sets(input int unsigned send_pct, input int unsigned recv_pct,
			input int unsigned long_size);
		int unsigned sent;
		int unsigned size;
		bit long_done;
		send_idle_pct = send_pct;
		recv_idle_pct <= recv_pct;
		sent = 0;
		long_done = 1'b0;
		while (sent < ITEMS_PER_PHASE) begin
			if (!long_done && sent >= 30) begin
				size = long_size;
				long_done = 1'b1;
			end else if ($urandom_range(9) == 0) begin
				size = $urandom_range(30, 13);
			end else begin
				size = $urandom_range(12, 1);
			end
			send_set(size);
			sent += size;
			if ($urandom_range(9) == 0) begin
				wait_drained();
			end
		end
		wait_drained();
	endtask

	// Result side: a requested long hold wins, else stall at random.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			result_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req_cnt != hold_ack_cnt) begin
			result_stall <= 1'b1;
			hold_ack_cnt <= hold_req_cnt;
			hold_left <= HOLD_CYCLES;
		end else begin
			result_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Compare every accepted result with the oldest expected entry.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_sorted.size() == 0) begin
				flag_error($sformatf("unexpected result: value %0d end %0b ovf %0b",
					result.sorted_value, result.end_of_list, result.overflowed));
			end else begin
				want = pending_sorted.pop_front();
				if (result.sorted_value !== want.sorted_value
						|| result.end_of_list !== want.end_of_list
						|| result.overflowed !== want.overflowed) begin
					flag_error($sformatf(
						"mismatch: expected value %0d end %0b ovf %0b, got value %0d end %0b ovf %0b",
						want.sorted_value, want.end_of_list, want.overflowed,
						result.sorted_value, result.end_of_list, result.overflowed));
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 31;
		recv_idle_pct <= 71;
		test_extremes();
		test_ties();
		test_order();
		test_backpressure();

		// full store closes exactly, then the closing item is dropped, then more
		test_random_sets(31, 71, STORE_DEPTH);
		test_random_sets(71, 31, STORE_DEPTH + 1);
		test_random_sets(0, 0, $urandom_range(STORE_DEPTH + 8, STORE_DEPTH + 2));

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_sorted.size() != 0) begin
			flag_error($sformatf("%0d expected results never arrived", pending_sorted.size()));
		end
		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
